>>> hdl/cksum_pkg.sv
// Shared types, constants and the CRC byte function for the checksum block.
`timescale 1ns / 1ps

package cksum_pkg;

    localparam logic [31:0] CRC_POLY     = 32'h04C1_1DB7;
    localparam logic [7:0]  NEWLINE_BYTE = 8'h0A;
    localparam logic [31:0] LINE_MAX     = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } in_word_t;

    typedef struct packed {
        logic [31:0] checksum;
        logic [63:0] byte_count;
        logic [31:0] line_count;
    } out_word_t;

    typedef enum logic [0:0] {
        S_IDLE,
        S_FOLD
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic take_byte;   // accepted word carries a byte
        logic load_rest;   // accepted word ends the message
        logic fold;        // fold the low byte of the remaining length
        logic finish;      // publish the result and clear the message
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic rest_zero;
        logic out_busy;    // output register full and not taken this cycle
    } status_t;

    // MSB-first CRC-32 update over one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {b, 24'd0};
        for (int i = 0; i < 8; i++)
        begin
            if (c[31])
                c = {c[30:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[30:0], 1'b0};
        end
        return c;
    endfunction

endpackage

>>> hdl/cksum_dp.sv
// Datapath: CRC, byte and line counters, length folding and the output register.
`timescale 1ns / 1ps

module cksum_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [31:0]        cfg_wr_data,
    input  cksum_pkg::in_word_t  in_data,
    input  cksum_pkg::cmd_t      cmd,
    output cksum_pkg::status_t   status,
    output logic               out_valid,
    input  logic               out_stall,
    output cksum_pkg::out_word_t out_data
);
    import cksum_pkg::*;

    logic [31:0] init_reg;
    logic [31:0] crc_reg,  crc_next;
    logic [63:0] len_reg,  len_next;
    logic [31:0] nl_reg,   nl_next;
    logic [63:0] rest_reg, rest_next;
    logic        out_valid_reg, out_valid_next;
    out_word_t   out_reg, out_next;

    always_comb
    begin
        crc_next  = crc_reg;
        len_next  = len_reg;
        nl_next   = nl_reg;
        rest_next = rest_reg;

        if (cmd.take_byte)
        begin
            crc_next = crc_byte(crc_reg, in_data.data_byte);
            len_next = len_reg + 64'd1;
            if (in_data.data_byte == NEWLINE_BYTE && nl_reg != LINE_MAX)
                nl_next = nl_reg + 32'd1;
        end

        // the byte of the ending word counts toward the folded length
        if (cmd.load_rest)
            rest_next = len_next;

        if (cmd.fold)
        begin
            crc_next  = crc_byte(crc_reg, rest_reg[7:0]);
            rest_next = {8'd0, rest_reg[63:8]};
        end

        if (cmd.finish)
        begin
            crc_next = init_reg;
            len_next = 64'd0;
            nl_next  = 32'd0;
        end
    end

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (cmd.finish)
        begin
            out_next.checksum   = ~crc_reg;
            out_next.byte_count = len_reg;
            out_next.line_count = nl_reg;
            out_valid_next      = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg      <= 32'd0;
            crc_reg       <= 32'd0;
            len_reg       <= 64'd0;
            nl_reg        <= 32'd0;
            rest_reg      <= 64'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                init_reg <= cfg_wr_data;
            crc_reg       <= crc_next;
            len_reg       <= len_next;
            nl_reg        <= nl_next;
            rest_reg      <= rest_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign status.rest_zero = (rest_reg == 64'd0);
    assign status.out_busy  = out_valid_reg && out_stall;
    assign out_valid        = out_valid_reg;
    assign out_data         = out_reg;

endmodule

>>> hdl/cksum_ctrl.sv
// Controller: accepts words, sequences the length fold and hands off the result.
`timescale 1ns / 1ps

module cksum_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_has_byte,
    input  logic               in_last,
    output logic               in_stall,
    input  cksum_pkg::status_t status,
    output cksum_pkg::cmd_t    cmd
);
    import cksum_pkg::*;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_last)
                    state_next = S_FOLD;
            end
            S_FOLD:
            begin
                if (status.rest_zero && !status.out_busy)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall      = 1'b1;
        cmd           = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_stall      = 1'b0;
                cmd.take_byte = in_valid && in_has_byte;
                cmd.load_rest = in_valid && in_last;
            end
            S_FOLD:
            begin
                cmd.fold   = !status.rest_zero;
                cmd.finish = status.rest_zero && !status.out_busy;
            end
            default: in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> hdl/cksum_crc32_with_length.sv
// Top level of the cksum-style CRC-32 block with byte and line counts.
`timescale 1ns / 1ps

// CRC-32 (poly 0x04C11DB7, MSB first) over a byte stream, one word per byte,
// with a 64-bit wrapping byte count and a saturating newline count. Words
// without last are accepted back to back. After a word with last, the length
// is folded into the CRC one byte per cycle by the datapath's fold step, one
// step for each significant byte of the byte count (0 to 8), then the
// complemented CRC and both counts move to the output register, waiting while
// that register still holds an untaken result. Input is stalled during the
// fold and that wait. A written initial_value loads the CRC when the current
// message ends (after reset the CRC starts at zero), so it applies from the
// message after the next result.
module cksum_crc32_with_length (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [31:0]          cfg_wr_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  cksum_pkg::in_word_t  in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output cksum_pkg::out_word_t out_data
);
    import cksum_pkg::*;

    cmd_t    cmd;
    status_t status;

    cksum_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_has_byte (in_data.has_byte),
        .in_last     (in_data.last),
        .in_stall    (in_stall),
        .status      (status),
        .cmd         (cmd)
    );

    cksum_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_data     (in_data),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

endmodule
